// ===== hdl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: sizes, derived widths and opcodes.
// No dependencies; imported by lru_key_value_cache_unit.
package lkvc_pkg;

    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 4;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_opcode;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;

endpackage

// ===== hdl/lru_key_value_cache_unit.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Throughput: one transaction per cycle while the output register is free; lookup,
// rank ageing and write happen in the same cycle; the result goes to the output register.
// The output register frees its slot in the same cycle as it is taken downstream.
// Reset (synchronous, active low) clears valid bits, ranks, fill count and output
// valid, and sets capacity to 8; stored keys and values are not cleared.
module lru_key_value_cache_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [3:0]               i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  lkvc_pkg::t_opcode        i_opcode,
    input  lkvc_pkg::t_key           i_key,
    input  lkvc_pkg::t_value         i_write_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_hit,
    output lkvc_pkg::t_value         o_read_value
);
    import lkvc_pkg::*;

    // Entry storage and control state
    t_key               r_key   [ENTRIES];
    t_value             r_value [ENTRIES];
    t_idx               r_rank  [ENTRIES];
    t_idx               n_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CAP_BITS-1:0] r_capacity;

    // Output register
    logic               r_out_valid;
    logic               r_out_hit;
    t_value             r_out_value;
    logic               n_out_hit;
    t_value             n_out_value;

    // Lookup and replacement signals
    logic               accept;
    logic               is_set;
    logic               hit_any;
    t_idx               hit_idx;
    t_idx               free_idx;
    t_idx               victim_idx;
    t_idx               target;
    t_idx               hit_rank;
    t_idx               oldest_rank;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   count_ext;
    logic               fill;
    logic               do_update;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign is_set     = (i_opcode == OP_SET);

    // Clamp capacity to 1..ENTRIES
    always_comb begin
        cap_eff = CMP_W'(r_capacity);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign count_ext   = CMP_W'(r_count);
    assign fill        = count_ext < cap_eff;
    assign oldest_rank = IDX_W'(r_count - CNT_W'(1));

    // Match keys in parallel; lowest index wins each search
    always_comb begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
            if (r_valid[i] && (r_rank[i] == oldest_rank)) begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    assign hit_rank  = r_rank[hit_idx];
    assign target    = hit_any ? hit_idx : (fill ? free_idx : victim_idx);
    assign do_update = accept && (hit_any || is_set);

    // Age entries more recent than the target; a miss ages every other valid entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (IDX_W'(i) == target) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (!hit_any || (r_rank[i] < hit_rank))) begin
                n_rank[i] = r_rank[i] + IDX_W'(1);
            end
        end
    end

    // Form the result
    always_comb begin
        n_out_hit   = hit_any;
        n_out_value = '0;
        if (hit_any && !is_set) begin
            n_out_value = r_value[hit_idx];
        end
    end

    // Hold capacity, valid bits, ranks and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_BITS'(8);
            r_valid    <= '0;
            r_count    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (do_update) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
                r_valid[target] <= 1'b1;
                if (!hit_any && fill) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Write key and value on a set
    always_ff @(posedge i_clk) begin
        if (accept && is_set) begin
            r_key[target]   <= i_key;
            r_value[target] <= i_write_value;
        end
    end

    // Advance the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_hit   <= n_out_hit;
            r_out_value <= n_out_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'($countones(r_valid)) == r_count)
        else $error("fill count differs from number of valid entries");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_ext <= CMP_W'(ENTRIES))
        else $error("fill count above number of entries");

    a_miss_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_value == '0))
        else $error("miss result carries a non-zero value");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted transaction produced no result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for lru_key_value_cache_unit: a directed table, then random get/set
// traffic over several capacity settings and idling phases. Depends on lkvc_pkg and lru_key_value_cache_unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 142;
    localparam int NUM_PHASES   = 8;
    localparam int NUM_ROWS     = 21;

    typedef struct {
        bit     hit;
        t_value value;
    } t_lookup_result;

    typedef struct {
        t_opcode op;
        t_key    key;
        t_value  wval;
        bit      typed;
        bit      hit;
        t_value  rval;
    } t_stim_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [3:0]    i_cfg_wr_data = 4'd0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    t_opcode       i_opcode = OP_GET;
    t_key          i_key = '0;
    t_value        i_write_value = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic          o_hit;
    t_value        o_read_value;

    // Expected result carried alongside a directed row, when typed in
    bit            row_typed = 1'b0;
    bit            row_hit = 1'b0;
    t_value        row_rval = '0;

    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles = 0;
    int            error_count = 0;

    t_lookup_result pending_results[$];

    // Shadow copy of the cache contents
    t_key          line_key[ENTRIES];
    t_value        line_value[ENTRIES];
    bit            line_valid[ENTRIES];
    int            line_rank[ENTRIES];
    int            fill_count;
    logic [3:0]    model_capacity;

    t_stim_row     directed_rows[NUM_ROWS];
    t_key          key_pool[16];

    lru_key_value_cache_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Make a line the most recent; lines more recent than it age by one
    function automatic void promote_line(input int e);
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (line_valid[i] && i != e && line_rank[i] < line_rank[e])
                line_rank[i]++;
        line_rank[e] = 0;
    endfunction

    // Look the key up, update contents and recency, and return the result
    function automatic void lru_lookup_update(input t_opcode op, input t_key key,
                                              input t_value wval, output bit hit,
                                              output t_value rval);
        int i;
        int found;
        int slot;
        int victim;
        int worst;
        int cap;
        found = -1;
        slot = -1;
        victim = -1;
        worst = -1;
        cap = model_capacity;
        if (cap < 1)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;
        for (i = 0; i < ENTRIES; i++)
            if (found < 0 && line_valid[i] && line_key[i] == key)
                found = i;
        hit = (found >= 0);
        rval = '0;
        if (found >= 0) begin
            if (op == OP_SET)
                line_value[found] = wval;
            else
                rval = line_value[found];
            promote_line(found);
            return;
        end
        if (op == OP_GET)
            return;
        // Fill the lowest free line while below capacity, else replace the oldest
        if (fill_count < cap)
            for (i = 0; i < ENTRIES; i++)
                if (slot < 0 && !line_valid[i])
                    slot = i;
        if (slot >= 0) begin
            for (i = 0; i < ENTRIES; i++)
                if (line_valid[i])
                    line_rank[i]++;
            line_valid[slot] = 1'b1;
            line_key[slot] = key;
            line_value[slot] = wval;
            line_rank[slot] = 0;
            fill_count++;
        end else begin
            for (i = 0; i < ENTRIES; i++)
                if (line_valid[i] && line_rank[i] > worst) begin
                    worst = line_rank[i];
                    victim = i;
                end
            if (victim >= 0) begin
                line_key[victim] = key;
                line_value[victim] = wval;
                promote_line(victim);
            end
        end
    endfunction

    // Track resets, register writes and both handshakes; compare results in order
    always @(posedge i_clk) begin : scoreboard
        bit             took;
        bit             p_hit;
        t_value         p_rval;
        t_lookup_result exp_res;
        took = 1'b0;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                line_valid[i] = 1'b0;
                line_rank[i] = 0;
                line_key[i] = '0;
                line_value[i] = '0;
            end
            fill_count = 0;
            model_capacity = 4'd8;
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                took = 1'b1;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual hit %0b value %h",
                             $time, o_hit, o_read_value);
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_hit !== exp_res.hit) begin
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, exp_res.hit, o_hit);
                        error_count++;
                    end
                    if (o_read_value !== exp_res.value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, exp_res.value, o_read_value);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                took = 1'b1;
                lru_lookup_update(i_opcode, i_key, i_write_value, p_hit, p_rval);
                if (row_typed) begin
                    p_hit = row_hit;
                    p_rval = row_rval;
                end
                pending_results.push_back('{p_hit, p_rval});
            end
            if (i_cfg_wr_en) begin
                took = 1'b1;
                model_capacity = i_cfg_wr_data;
            end
            quiet_cycles = took ? 0 : quiet_cycles + 1;
        end
    end

    // Stall the result side at the rate set for the phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // End the run if nothing has moved for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("lru_key_value_cache_unit: mismatch");
        $finish;
    end

    // Offer one transaction, idling first at the phase rate; return on acceptance
    task automatic offer_request(input t_opcode op, input t_key key, input t_value wval,
                                 input bit typed, input bit thit, input t_value trval);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_key         <= key;
        i_write_value <= wval;
        row_typed     <= typed;
        row_hit       <= thit;
        row_rval      <= trval;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // Drop valid and wait for every result before the block counts as idle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [3:0] phase_caps[NUM_PHASES];
        t_opcode    op;
        t_key       key;
        int         pool_n;

        phase_caps = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd8, 4'd5, 4'd2, 4'd12};

        // Extremes, hits and misses of both kinds, then a full cache and two evictions
        directed_rows = '{
            '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
            '{OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
            '{OP_SET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000},
            '{OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h1234_5678},
            '{OP_SET, 32'h0000_0001, 32'hA5A5_0001, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h8000_0001, 32'h5A5A_0002, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0002, 32'hA5A5_0003, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0003, 32'hA5A5_0004, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0004, 32'hA5A5_0005, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0005, 32'hA5A5_0006, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0006, 32'hA5A5_0007, 1'b1, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'h8000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
            '{OP_SET, 32'h0000_0007, 32'hA5A5_0008, 1'b0, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
            '{OP_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
        };

        // Hold reset, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset capacity, no idling
        foreach (directed_rows[r])
            offer_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].wval,
                          directed_rows[r].typed, directed_rows[r].hit,
                          directed_rows[r].rval);

        // Random phases: new capacity, idling mode and key pool each time
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= phase_caps[p];
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;

            send_idle_pct  = (p % 4 == 1) ? 82 : (p % 4 == 3) ? 31 : 0;
            recv_stall_pct = (p % 4 == 2) ? 82 : (p % 4 == 3) ? 31 : 0;

            foreach (key_pool[k])
                key_pool[k] = $urandom();
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            pool_n = $urandom_range(2, 12);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mostly keys from the pool so that hits and evictions are frequent
                if ($urandom_range(0, 9) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(0, pool_n - 1)];
                op = ($urandom_range(0, 1) == 1) ? OP_SET : OP_GET;
                offer_request(op, key, $urandom(), 1'b0, 1'b0, '0);
            end
        end

        drain_results();
        if (error_count == 0)
            $display("lru_key_value_cache_unit: match");
        else
            $display("lru_key_value_cache_unit: mismatch");
        $finish;
    end

endmodule
